/* design/bkhs_pkg.sv */
`timescale 1ns / 1ps

package bkhs_pkg;

  localparam int HkeyBitsDefault = 64;
  localparam int OutKeyW = 64;
  localparam int SlotW = 24;
  localparam int ByteW = 8;
  localparam int HashW = 32;
  localparam int ShamtW = 5;
  localparam int StepW = 4;
  localparam int AddrW = 3;
  localparam int DataW = 32;

  // register index, taken from paddr[2]
  localparam logic RegTableSize = 1'b0;

  // sequencer steps
  localparam logic [StepW-1:0] StepAbsorb = 4'd0;
  localparam logic [StepW-1:0] StepAbsorbEnd = 4'd2;
  localparam logic [StepW-1:0] StepAvalanche = 4'd3;
  localparam logic [StepW-1:0] StepLast = 4'd11;

  typedef enum logic [2:0] {
    OP_ADD_BYTE,
    OP_ADD_SHL,
    OP_XOR_SHL,
    OP_XOR_SHR,
    OP_NOT_ADD_SHR,
    OP_OR_ONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ShamtW-1:0] shamt;
    logic              narrow;
  } uop_t;

  // one-at-a-time absorb, final avalanche, then remix at full key width
  function automatic uop_t uop_lookup(input logic [StepW-1:0] step);
    uop_t u;
    u = '{op: OP_OR_ONE, shamt: 5'd0, narrow: 1'b0};
    unique case (step)
      4'd0:  u = '{op: OP_ADD_BYTE,    shamt: 5'd0,  narrow: 1'b1};
      4'd1:  u = '{op: OP_ADD_SHL,     shamt: 5'd10, narrow: 1'b1};
      4'd2:  u = '{op: OP_XOR_SHR,     shamt: 5'd6,  narrow: 1'b1};
      4'd3:  u = '{op: OP_ADD_SHL,     shamt: 5'd3,  narrow: 1'b1};
      4'd4:  u = '{op: OP_XOR_SHR,     shamt: 5'd11, narrow: 1'b1};
      4'd5:  u = '{op: OP_ADD_SHL,     shamt: 5'd15, narrow: 1'b1};
      4'd6:  u = '{op: OP_NOT_ADD_SHR, shamt: 5'd23, narrow: 1'b0};
      4'd7:  u = '{op: OP_XOR_SHL,     shamt: 5'd12, narrow: 1'b0};
      4'd8:  u = '{op: OP_XOR_SHR,     shamt: 5'd7,  narrow: 1'b0};
      4'd9:  u = '{op: OP_XOR_SHL,     shamt: 5'd2,  narrow: 1'b0};
      4'd10: u = '{op: OP_XOR_SHR,     shamt: 5'd20, narrow: 1'b0};
      4'd11: u = '{op: OP_OR_ONE,      shamt: 5'd0,  narrow: 1'b0};
      default: u = '{op: OP_OR_ONE, shamt: 5'd0, narrow: 1'b0};
    endcase
    return u;
  endfunction

endpackage

/* design/byte_key_hash_and_slot.sv */
`timescale 1ns / 1ps

// Byte-serial one-at-a-time key hash with slot selection. Feed a key one byte
// per beat; the beat with in_last_byte set (with or without a byte) closes the
// key and yields one result beat: the remixed, always odd hash key and that key
// modulo table_size (0 counts as 1). A key byte is accepted and then runs three
// steps of the shared shift/add/xor unit. Closing a key adds nine more unit
// steps of avalanche and remix, then a restoring divide of one key bit per
// cycle and a hand-over of the result to the output register; a close with no
// byte skips the three absorb steps. in_ready is high only while the sequencer
// is idle; a result waiting in the output register does not block new bytes,
// only the close of the next key. table_size sits at byte address 0 of the APB
// port and must be written only while the block is idle.
module byte_key_hash_and_slot #(
  parameter int HKEY_BITS = bkhs_pkg::HkeyBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bkhs_pkg::ByteW-1:0]          in_key_byte,
  input  logic                                in_byte_present,
  input  logic                                in_last_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bkhs_pkg::OutKeyW-1:0]        out_hash_key,
  output logic [bkhs_pkg::SlotW-1:0]          out_slot_index,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bkhs_pkg::AddrW-1:0]          paddr,
  input  logic [bkhs_pkg::DataW-1:0]          pwdata,
  output logic [bkhs_pkg::DataW-1:0]          prdata,
  output logic                                pready
);

  localparam int CntW = $clog2(HKEY_BITS);
  localparam int SlotW = bkhs_pkg::SlotW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t                          state_r, state_nxt;
  logic [HKEY_BITS-1:0]            acc_r, acc_nxt;
  logic [bkhs_pkg::ByteW-1:0]      byte_r, byte_nxt;
  logic                            last_r, last_nxt;
  logic [bkhs_pkg::StepW-1:0]      step_r, step_nxt;
  logic [CntW-1:0]                 bit_cnt_r, bit_cnt_nxt;
  logic [SlotW-1:0]                rem_r, rem_nxt;
  logic [SlotW-1:0]                table_size_r, table_size_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [bkhs_pkg::OutKeyW-1:0]    out_key_r, out_key_nxt;
  logic [SlotW-1:0]                out_slot_r, out_slot_nxt;

  bkhs_pkg::uop_t                  uop;
  logic [HKEY_BITS-1:0]            width_mask;
  logic [HKEY_BITS-1:0]            shl_val;
  logic [HKEY_BITS-1:0]            shr_val;
  logic [HKEY_BITS-1:0]            alu_raw;
  logic [HKEY_BITS-1:0]            alu_out;
  logic [SlotW-1:0]                divisor;
  logic [SlotW:0]                  trial;
  logic                            trial_ge;
  logic [SlotW-1:0]                trial_rem;
  logic [bkhs_pkg::OutKeyW-1:0]    key_ext;
  logic                            out_free;
  logic                            in_beat;
  logic                            cfg_wr;

  assign in_ready = (state_r == ST_IDLE);
  assign in_beat = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_hash_key = out_key_r;
  assign out_slot_index = out_slot_r;
  assign out_free = !out_valid_r || out_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == bkhs_pkg::RegTableSize)
                ? {{(bkhs_pkg::DataW - SlotW){1'b0}}, table_size_r}
                : '0;

  // shared shift/add/xor unit
  always_comb begin
    uop = bkhs_pkg::uop_lookup(step_r);
    width_mask = '1;
    if (uop.narrow) begin
      width_mask = '0;
      width_mask[bkhs_pkg::HashW-1:0] = '1;
    end
    shl_val = acc_r << uop.shamt;
    shr_val = acc_r >> uop.shamt;
    alu_raw = acc_r;
    case (uop.op)
      bkhs_pkg::OP_ADD_BYTE:    alu_raw = acc_r + HKEY_BITS'(byte_r);
      bkhs_pkg::OP_ADD_SHL:     alu_raw = acc_r + shl_val;
      bkhs_pkg::OP_XOR_SHL:     alu_raw = acc_r ^ shl_val;
      bkhs_pkg::OP_XOR_SHR:     alu_raw = acc_r ^ shr_val;
      bkhs_pkg::OP_NOT_ADD_SHR: alu_raw = ~acc_r + shr_val;
      bkhs_pkg::OP_OR_ONE:      alu_raw = acc_r | HKEY_BITS'(1);
      default:                  alu_raw = acc_r;
    endcase
    alu_out = alu_raw & width_mask;
  end

  // one restoring divide step per cycle, key bits msb first
  always_comb begin
    divisor = (table_size_r == '0) ? SlotW'(1) : table_size_r;
    trial = {rem_r, acc_r[bit_cnt_r]};
    trial_ge = (trial >= {1'b0, divisor});
    trial_rem = trial_ge ? SlotW'(trial - {1'b0, divisor}) : trial[SlotW-1:0];
    key_ext = '0;
    key_ext[HKEY_BITS-1:0] = acc_r;
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt = acc_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    step_nxt = step_r;
    bit_cnt_nxt = bit_cnt_r;
    rem_nxt = rem_r;
    table_size_nxt = table_size_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt = out_key_r;
    out_slot_nxt = out_slot_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_wr && paddr[2] == bkhs_pkg::RegTableSize) begin
      table_size_nxt = pwdata[SlotW-1:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          byte_nxt = in_key_byte;
          last_nxt = in_last_byte;
          if (in_byte_present) begin
            step_nxt = bkhs_pkg::StepAbsorb;
            state_nxt = ST_RUN;
          end else if (in_last_byte) begin
            // close the key without a new byte
            step_nxt = bkhs_pkg::StepAvalanche;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        acc_nxt = alu_out;
        step_nxt = step_r + 1'b1;
        if (step_r == bkhs_pkg::StepAbsorbEnd && !last_r) begin
          state_nxt = ST_IDLE;
        end else if (step_r == bkhs_pkg::StepLast) begin
          bit_cnt_nxt = CntW'(HKEY_BITS - 1);
          rem_nxt = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = trial_rem;
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        if (bit_cnt_r == '0) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_key_nxt = key_ext;
          out_slot_nxt = rem_r;
          // running hash starts over for the next key
          acc_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      acc_r <= '0;
      table_size_r <= SlotW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r <= acc_nxt;
      table_size_r <= table_size_nxt;
      out_valid_r <= out_valid_nxt;
    end
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    step_r <= step_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    rem_r <= rem_nxt;
    out_key_r <= out_key_nxt;
    out_slot_r <= out_slot_nxt;
  end

  a_key_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_key_r[0])
    else $error("result key is even");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV || state_r == ST_HOLD) |-> (rem_r < divisor))
    else $error("divide remainder not below divisor");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && bit_cnt_r == '0) |=> (state_r == ST_HOLD))
    else $error("divide did not end after last key bit");

  a_narrow_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ((acc_r >> bkhs_pkg::HashW) == '0))
    else $error("running hash wider than 32 bits");

endmodule

/* dv/byte_key_hash_and_slot_test.sv */
`timescale 1ns / 1ps

typedef struct {
  bit [bkhs_pkg::OutKeyW-1:0] hash_key;
  bit [bkhs_pkg::SlotW-1:0]   slot_index;
} key_slot_t;

class key_hash_board;
  bit [bkhs_pkg::HashW-1:0] running_hash;
  bit [bkhs_pkg::SlotW-1:0] table_size;
  key_slot_t                pending_keys[$];
  int                       errors;

  function new();
    running_hash = '0;
    table_size   = 24'd1;
    errors       = 0;
  endfunction

  function void write_reg(input int unsigned index, input bit [bkhs_pkg::DataW-1:0] value);
    if (index == bkhs_pkg::RegTableSize) begin
      table_size = value[bkhs_pkg::SlotW-1:0];
    end
  endfunction

  // one-at-a-time absorb per byte; on close: avalanche, remix, slot
  function void note_beat(input bit [7:0] key_byte, input bit present, input bit last);
    bit [31:0] h;
    bit [63:0] m;
    bit [63:0] n;
    bit [63:0] div;
    bit [63:0] slot;
    key_slot_t r;
    if (present) begin
      h = running_hash + {24'b0, key_byte};
      h = h + (h << 10);
      h = h ^ (h >> 6);
      running_hash = h;
    end
    if (!last) return;
    h = running_hash;
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    m = {64{1'b1}} >> (64 - bkhs_pkg::HkeyBitsDefault);
    n = {32'b0, h} & m;
    n = (~n + (n >> 23)) & m;
    n = (n ^ (n << 12)) & m;
    n = n ^ (n >> 7);
    n = (n ^ (n << 2)) & m;
    n = n ^ (n >> 20);
    n = (n | 64'd1) & m;
    running_hash = '0;
    // zero table size acts as one slot
    div = (table_size == 0) ? 64'd1 : {40'b0, table_size};
    slot = n % div;
    r.hash_key   = n;
    r.slot_index = slot[23:0];
    pending_keys.push_back(r);
  endfunction

  function void check_beat(input bit [63:0] hash_key, input bit [23:0] slot_index);
    key_slot_t e;
    if (pending_keys.size() == 0) begin
      $display("%0t unexpected result beat: hash_key %h slot_index %h",
               $time, hash_key, slot_index);
      errors++;
      return;
    end
    e = pending_keys.pop_front();
    if (hash_key !== e.hash_key) begin
      $display("%0t hash_key mismatch: expected %h actual %h", $time, e.hash_key, hash_key);
      errors++;
    end
    if (slot_index !== e.slot_index) begin
      $display("%0t slot_index mismatch: expected %h actual %h",
               $time, e.slot_index, slot_index);
      errors++;
    end
  endfunction

  function int pending();
    return pending_keys.size();
  endfunction
endclass

module byte_key_hash_and_slot_test;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [bkhs_pkg::ByteW-1:0]   in_key_byte;
  logic                         in_byte_present;
  logic                         in_last_byte;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [bkhs_pkg::OutKeyW-1:0] out_hash_key;
  logic [bkhs_pkg::SlotW-1:0]   out_slot_index;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [bkhs_pkg::AddrW-1:0]   paddr;
  logic [bkhs_pkg::DataW-1:0]   pwdata;
  logic [bkhs_pkg::DataW-1:0]   prdata;
  logic                         pready;

  key_hash_board board;
  int            tx_idle_pct;
  int            rx_idle_pct;
  int            beats_sent;

  byte_key_hash_and_slot u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_key_byte     (in_key_byte),
    .in_byte_present (in_byte_present),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hash_key    (out_hash_key),
    .out_slot_index  (out_slot_index),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check accepted beats, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_beat(out_hash_key, out_slot_index);
    end
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_beat(input bit [7:0] key_byte, input bit present, input bit last);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid        <= 1'b1;
    in_key_byte     <= key_byte;
    in_byte_present <= present;
    in_last_byte    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_beat(key_byte, present, last);
    if (present || last) beats_sent++;
  endtask

  // hold the sender until every pending key has come out
  task automatic wait_drained(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_access(input bit wr, input bit [2:0] addr, input bit [31:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr) begin
      board.write_reg(int'(addr >> 2), wdata);
    end else if (prdata !== {8'b0, board.table_size}) begin
      $display("%0t table_size read mismatch: expected %h actual %h",
               $time, {8'b0, board.table_size}, prdata);
      board.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // one key with random bytes; idle beats sprinkled in, sometimes closed by a marker beat
  task automatic send_random_key();
    int len;
    int pick;
    bit marker_close;
    pick = $urandom_range(99);
    if (pick < 5) len = 0;
    else if (pick < 85) len = $urandom_range(1, 6);
    else len = $urandom_range(7, 20);
    marker_close = ($urandom_range(99) < 20);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 10) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(8'($urandom_range(255)), 1'b1, (i == len - 1) && !marker_close);
    end
    if (len == 0 || marker_close) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic run_phase(input int target, input int tx_pct, input int rx_pct);
    int start;
    bit paused;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start  = beats_sent;
    paused = 1'b0;
    while (beats_sent - start < target) begin
      send_random_key();
      if (!paused && beats_sent - start >= target / 2) begin
        wait_drained(0);
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int guard;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_key_byte     <= '0;
    in_byte_present <= 1'b0;
    in_last_byte    <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    tx_idle_pct = 0;
    rx_idle_pct = 50;
    beats_sent  = 0;
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset table size, empty key, extreme bytes
    cfg_access(1'b0, 3'd0, 32'd0);
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b1);
    wait_drained(100);

    // zero table size, idle beat mid-key, key closed by a marker beat
    cfg_access(1'b1, 3'd0, 32'd0);
    cfg_access(1'b0, 3'd0, 32'd0);
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h7F, 1'b1, 1'b1);
    send_beat(8'h12, 1'b1, 1'b0);
    send_beat(8'h34, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    wait_drained(100);

    // largest table size, upper data bits dropped
    cfg_access(1'b1, 3'd0, 32'hFFFF_FFFF);
    cfg_access(1'b0, 3'd0, 32'd0);
    send_beat(8'hA5, 1'b1, 1'b0);
    send_beat(8'h5A, 1'b1, 1'b0);
    send_beat(8'hC3, 1'b1, 1'b0);
    send_beat(8'h3C, 1'b1, 1'b1);
    send_beat(8'h00, 1'b0, 1'b1);
    wait_drained(100);

    // write to a register that does not exist is dropped
    cfg_access(1'b1, 3'd7, 32'h0000_0007);
    cfg_access(1'b0, 3'd0, 32'd0);
    cfg_access(1'b1, 3'd0, 32'd1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b1);
    wait_drained(100);

    cfg_access(1'b1, 3'd0, $urandom_range(2, 300));
    run_phase(135, 26, 84);
    wait_drained(100);

    cfg_access(1'b1, 3'd0, $urandom);
    cfg_access(1'b1, 3'd7, $urandom);
    cfg_access(1'b0, 3'd0, 32'd0);
    run_phase(135, 84, 26);
    wait_drained(100);

    cfg_access(1'b1, 3'd0, 32'd3);
    run_phase(135, 0, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (board.pending() != 0 && guard < 50_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (board.pending() != 0) begin
      $display("%0t %0d expected results never arrived", $time, board.pending());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
